// ----- design/spg_pkg.sv -----
// ----------------------------------------------------------------------------
// spg_pkg
// Shared widths, defaults and helpers for the shuffle permutation generator.
// ----------------------------------------------------------------------------
package spg_pkg;

   localparam int SIZE_W        = 9;
   localparam int WORD_W        = 31;
   localparam int VALUE_W       = 8;
   localparam int BIT_CNT_W     = $clog2(WORD_W);
   localparam int MAX_SLOTS_DEF = 256;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

   // zero means one, anything above the table depth saturates
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] raw,
                                                  input int unsigned max_slots);
      logic [SIZE_W-1:0] s;
      s = raw;
      if (raw == '0) begin
         s = SIZE_W'(1);
      end else if (32'(raw) > max_slots) begin
         s = SIZE_W'(max_slots);
      end
      return s;
   endfunction

endpackage

// ----- design/spg_req_if.sv -----
// ----------------------------------------------------------------------------
// spg_req_if
// Request channel: one random word per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface spg_req_if;
   logic                        valid;
   logic                        ready;
   logic [spg_pkg::WORD_W-1:0]  random_word;

   modport source (output valid, output random_word, input ready);
   modport sink   (input valid, input random_word, output ready);
endinterface

// ----- design/spg_rsp_if.sv -----
// ----------------------------------------------------------------------------
// spg_rsp_if
// Response channel: one permutation value per item plus end marker.
// ----------------------------------------------------------------------------
interface spg_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [spg_pkg::VALUE_W-1:0] chosen_value;
   logic                        last;

   modport source (output valid, output chosen_value, output last, input ready);
   modport sink   (input valid, input chosen_value, input last, output ready);
endinterface

// ----- design/shuffle_permutation_generator.sv -----
// ----------------------------------------------------------------------------
// shuffle_permutation_generator
// Random permutation of 0..size-1 by linear probing over a taken table.
//
// Each request item carries a random word; the block replies with one
// permutation value per item, and flags last on the value that completes
// the permutation, after which a fresh permutation begins.
// The word is reduced modulo the size one bit per cycle, then the taken
// table is probed from that slot upward, wrapping at size-1, each probed
// slot taking a read state and a check state (one-port table, registered
// read data). After the last value of a permutation, after reset and after
// any csr write, the table is cleared one slot per cycle over size slots;
// no item is taken meanwhile. A csr write sets the size (0 acts as 1) and
// restarts the permutation. The result sits in an output register: the
// next item is taken while it waits, but its own result is held until the
// receiver takes the first. Reset is synchronous and active high.
// ----------------------------------------------------------------------------
module shuffle_permutation_generator #(
   parameter int MAX_SLOTS = spg_pkg::MAX_SLOTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   spg_req_if.sink                     req_bus,
   spg_rsp_if.source                   rsp_bus,
   input  logic                        csr_we,
   input  logic [spg_pkg::SIZE_W-1:0]  csr_wdata
);

   localparam int SIZE_W  = spg_pkg::SIZE_W;
   localparam int WORD_W  = spg_pkg::WORD_W;
   localparam int VALUE_W = spg_pkg::VALUE_W;
   localparam int CNT_W   = spg_pkg::BIT_CNT_W;
   localparam int SLOT_W  = $clog2(MAX_SLOTS);
   localparam int CMP_W   = (SLOT_W > SIZE_W ? SLOT_W : SIZE_W) + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_RD,
      ST_CHK,
      ST_EMIT,
      ST_SWEEP
   } state_type;

   state_type           state_ff, state_in;
   logic [WORD_W-1:0]   word_ff, word_in;
   logic [CNT_W-1:0]    bit_cnt_ff, bit_cnt_in;
   logic [SIZE_W-1:0]   rem_ff, rem_in;
   logic [SLOT_W-1:0]   probe_ff, probe_in;
   logic [SIZE_W-1:0]   tries_ff, tries_in;
   logic [SIZE_W-1:0]   count_ff, count_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic                fail_ff, fail_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                taken_mem [MAX_SLOTS];
   logic                rd_data_ff;
   logic                mem_we;
   logic                mem_wdata;

   logic [SIZE_W:0]     rem_shift;
   logic [SIZE_W:0]     rem_diff;
   logic                probe_wrap;
   logic [SLOT_W-1:0]   probe_next;
   logic                out_free;
   logic                perm_done;

   assign req_bus.ready        = (state_ff == ST_IDLE);
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.chosen_value = rsp_value_ff;
   assign rsp_bus.last         = rsp_last_ff;

   // one restoring step of the modulo per cycle
   assign rem_shift = {rem_ff, word_ff[WORD_W-1]};
   assign rem_diff  = rem_shift - {1'b0, size_ff};

   assign probe_wrap = (CMP_W'(probe_ff) == CMP_W'(size_ff) - CMP_W'(1));
   assign probe_next = probe_wrap ? '0 : probe_ff + SLOT_W'(1);
   assign out_free   = !rsp_valid_ff || rsp_bus.ready;
   assign perm_done  = fail_ff || (({1'b0, count_ff} + (SIZE_W+1)'(1)) >= {1'b0, size_ff});

   assign mem_we    = ((state_ff == ST_EMIT) && out_free && !fail_ff) ||
                      (state_ff == ST_SWEEP);
   assign mem_wdata = (state_ff == ST_EMIT);

   always_comb begin
      state_in     = state_ff;
      word_in      = word_ff;
      bit_cnt_in   = bit_cnt_ff;
      rem_in       = rem_ff;
      probe_in     = probe_ff;
      tries_in     = tries_ff;
      count_in     = count_ff;
      size_in      = size_ff;
      fail_in      = fail_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               word_in    = req_bus.random_word;
               bit_cnt_in = CNT_W'(WORD_W - 1);
               rem_in     = '0;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            word_in    = {word_ff[WORD_W-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - CNT_W'(1);
            if (rem_shift >= {1'b0, size_ff}) begin
               rem_in = rem_diff[SIZE_W-1:0];
            end else begin
               rem_in = rem_shift[SIZE_W-1:0];
            end
            if (bit_cnt_ff == '0) begin
               // final remainder is the start slot, addressed before the first read
               probe_in = SLOT_W'(rem_in);
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (!rd_data_ff) begin
               fail_in  = 1'b0;
               state_in = ST_EMIT;
            end else if ((tries_ff + SIZE_W'(1)) == size_ff) begin
               fail_in  = 1'b1;
               state_in = ST_EMIT;
            end else begin
               probe_in = probe_next;
               tries_in = tries_ff + SIZE_W'(1);
               state_in = ST_RD;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = fail_ff ? '0 : VALUE_W'(probe_ff);
               rsp_last_in  = perm_done;
               tries_in     = '0;
               if (perm_done) begin
                  count_in = '0;
                  probe_in = '0;
                  state_in = ST_SWEEP;
               end else begin
                  count_in = count_ff + SIZE_W'(1);
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SWEEP: begin
            probe_in = probe_next;
            if (probe_wrap) begin
               probe_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_SWEEP;
         end
      endcase

      if (csr_we) begin
         size_in  = spg_pkg::eff_size(csr_wdata, MAX_SLOTS);
         count_in = '0;
         tries_in = '0;
         probe_in = '0;
         state_in = ST_SWEEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         probe_ff     <= '0;
         tries_ff     <= '0;
         count_ff     <= '0;
         size_ff      <= spg_pkg::eff_size(spg_pkg::SIZE_RESET, MAX_SLOTS);
         fail_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         bit_cnt_ff   <= bit_cnt_in;
         rem_ff       <= rem_in;
         probe_ff     <= probe_in;
         tries_ff     <= tries_in;
         count_ff     <= count_in;
         size_ff      <= size_in;
         fail_ff      <= fail_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_value_ff <= rsp_value_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   // taken table, one port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         taken_mem[probe_ff] <= mem_wdata;
      end
      rd_data_ff <= taken_mem[probe_ff];
   end

`ifndef SYNTHESIS
   // values issued so far always stay below the permutation size
   a_count_below_size: assert property (@(posedge clock) disable iff (reset)
      count_ff < size_ff)
      else $error("issued count reached size");

   // probing and clearing never leave the active slot range
   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHK || state_ff == ST_SWEEP || state_ff == ST_EMIT) |->
      (CMP_W'(probe_ff) < CMP_W'(size_ff)))
      else $error("probe slot beyond size");

   // a correctly cleared table always leaves a free slot
   a_no_probe_fail: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> !fail_ff)
      else $error("no free slot found");

   // the remainder handed to the probe is already reduced
   a_rem_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && bit_cnt_ff == '0 && !csr_we) |=> (rem_ff < size_ff))
      else $error("modulo result not below size");
`endif

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the shuffle permutation generator. Each accepted
// random word is run through a bit-accurate permutation predictor, and every
// returned value and last flag is compared with the oldest prediction.
// Directed tests cover word extremes, zero and oversized sizes, wrap-around
// and rewrites in mid-permutation. Random phases follow, with idling on both
// channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

   localparam int SLOTS        = spg_pkg::MAX_SLOTS_DEF;
   localparam int RANDOM_ITEMS = 700;
   localparam int HOLD_LEN     = 400;
   localparam int DRAIN_CYCLES = 600;

   typedef struct packed {
      logic [spg_pkg::VALUE_W-1:0] value;
      logic                        last;
   } perm_value_type;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         csr_we;
   logic [spg_pkg::SIZE_W-1:0]   csr_wdata;

   spg_req_if req_bus ();
   spg_rsp_if rsp_bus ();

   shuffle_permutation_generator uut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   logic [spg_pkg::SIZE_W-1:0] size_reg = spg_pkg::SIZE_RESET;
   bit                taken_slots [SLOTS];
   int unsigned       issued_count;
   perm_value_type    expected_values [$];

   int unsigned mismatches = 0;
   bit          calm = 1'b0;
   int unsigned hold_requests = 0;
   int unsigned hold_seen = 0;
   int unsigned hold_left = 0;

   always #5 clock = ~clock;

   function automatic int unsigned span_of(input logic [spg_pkg::SIZE_W-1:0] raw);
      if (raw == '0) begin
         return 1;
      end else if (int'(raw) > SLOTS) begin
         return SLOTS;
      end
      return int'(raw);
   endfunction

   function automatic void restart_permutation();
      foreach (taken_slots[i]) begin
         taken_slots[i] = 1'b0;
      end
      issued_count = 0;
   endfunction

   function automatic perm_value_type draw_value(input logic [spg_pkg::WORD_W-1:0] word);
      int unsigned    span;
      int unsigned    slot;
      int unsigned    tries;
      bit             found;
      perm_value_type res;
      span  = span_of(size_reg);
      slot  = word % span;
      found = 1'b0;
      for (tries = 0; tries < span; tries++) begin
         if (!taken_slots[slot]) begin
            found = 1'b1;
            break;
         end
         slot = (slot + 1 >= span) ? 0 : slot + 1;
      end
      if (!found) begin
         res.value = '0;
         res.last  = 1'b1;
         restart_permutation();
         return res;
      end
      taken_slots[slot] = 1'b1;
      issued_count++;
      res.value = slot[spg_pkg::VALUE_W-1:0];
      res.last  = (issued_count >= span);
      if (res.last) begin
         restart_permutation();
      end
      return res;
   endfunction

   // receiver: random stalls, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= hold_left - 1;
      end else if (hold_seen != hold_requests) begin
         hold_seen     <= hold_requests;
         hold_left     <= HOLD_LEN;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= calm || ($urandom_range(99) >= 10);
      end
   end

   always @(posedge clock) begin
      perm_value_type exp_item;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_values.size() == 0) begin
            $error("chosen_value: no item expected, actual %0d (last %0b)",
                   rsp_bus.chosen_value, rsp_bus.last);
            mismatches++;
         end else begin
            exp_item = expected_values.pop_front();
            if (rsp_bus.chosen_value !== exp_item.value) begin
               $error("chosen_value: expected %0d, actual %0d",
                      exp_item.value, rsp_bus.chosen_value);
               mismatches++;
            end
            if (rsp_bus.last !== exp_item.last) begin
               $error("last: expected %0b, actual %0b", exp_item.last, rsp_bus.last);
               mismatches++;
            end
         end
      end
   end

   // called at a rising edge, returns at the edge where the item was taken
   task automatic send_word(input logic [spg_pkg::WORD_W-1:0] word);
      if (!calm && $urandom_range(99) < 10) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.random_word <= word;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      expected_values.push_back(draw_value(word));
   endtask

   task automatic finish_phase();
      req_bus.valid <= 1'b0;
      while (expected_values.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_size(input logic [spg_pkg::SIZE_W-1:0] raw);
      csr_we    <= 1'b1;
      csr_wdata <= raw;
      size_reg = raw;
      restart_permutation();
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic test_reset_default();
      send_word('0);
      send_word({spg_pkg::WORD_W{1'b1}});
      send_word(spg_pkg::WORD_W'(255));
      send_word(spg_pkg::WORD_W'(256));
      finish_phase();
   endtask

   task automatic test_size_zero();
      write_size('0);
      send_word({spg_pkg::WORD_W{1'b1}});
      send_word(spg_pkg::WORD_W'(12345));
      send_word('0);
      finish_phase();
   endtask

   task automatic test_size_one();
      write_size(spg_pkg::SIZE_W'(1));
      send_word(spg_pkg::WORD_W'(77));
      send_word({spg_pkg::WORD_W{1'b1}});
      finish_phase();
   endtask

   task automatic test_size_two();
      write_size(spg_pkg::SIZE_W'(2));
      // second word lands on a taken slot and wraps to zero
      send_word(spg_pkg::WORD_W'(1));
      send_word(spg_pkg::WORD_W'(1));
      send_word('0);
      send_word('0);
      finish_phase();
   endtask

   task automatic test_wrap_and_rewrite();
      write_size(spg_pkg::SIZE_W'(5));
      send_word(spg_pkg::WORD_W'(4));
      send_word(spg_pkg::WORD_W'(9));
      send_word(spg_pkg::WORD_W'(14));
      finish_phase();
      // same value rewritten mid-permutation starts afresh
      write_size(spg_pkg::SIZE_W'(5));
      send_word(spg_pkg::WORD_W'(4));
      finish_phase();
   endtask

   task automatic test_size_saturate();
      write_size({spg_pkg::SIZE_W{1'b1}});
      send_word({spg_pkg::WORD_W{1'b1}});
      send_word(spg_pkg::WORD_W'(511));
      finish_phase();
      write_size(spg_pkg::SIZE_W'(300));
      send_word(spg_pkg::WORD_W'(300));
      finish_phase();
   endtask

   task automatic test_full_permutation();
      write_size(spg_pkg::SIZE_W'(256));
      repeat (SLOTS + 20) send_word(spg_pkg::WORD_W'($urandom));
      finish_phase();
   endtask

   task automatic test_back_pressure();
      write_size(spg_pkg::SIZE_W'(12));
      hold_requests <= hold_requests + 1;
      repeat (30) send_word(spg_pkg::WORD_W'($urandom));
      finish_phase();
   endtask

   task automatic test_no_idling();
      calm <= 1'b1;
      write_size(spg_pkg::SIZE_W'(7));
      repeat (140) send_word(spg_pkg::WORD_W'($urandom));
      finish_phase();
      calm <= 1'b0;
   endtask

   task automatic test_random_sizes();
      int unsigned                sent;
      int unsigned                count;
      int unsigned                span;
      int unsigned                pick;
      logic [spg_pkg::SIZE_W-1:0] raw;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            raw = spg_pkg::SIZE_W'($urandom_range(1, 8));
         end else if (pick < 80) begin
            raw = spg_pkg::SIZE_W'($urandom_range(9, 40));
         end else if (pick < 88) begin
            raw = spg_pkg::SIZE_W'($urandom_range(41, 128));
         end else if (pick < 92) begin
            raw = '0;
         end else if (pick < 96) begin
            raw = spg_pkg::SIZE_W'($urandom_range(257, 511));
         end else begin
            raw = spg_pkg::SIZE_W'($urandom_range(129, 256));
         end
         span = span_of(raw);
         pick = $urandom_range(99);
         if (span > 128) begin
            // large sizes stay short and get rewritten part way
            count = $urandom_range(1, 40);
         end else if (pick < 60) begin
            count = span * ((span <= 16) ? $urandom_range(1, 3) : 1);
         end else if (pick < 85 && span > 1) begin
            count = $urandom_range(1, span - 1);
         end else begin
            count = $urandom_range(1, 2 * span);
         end
         write_size(raw);
         repeat (count) send_word(spg_pkg::WORD_W'($urandom));
         finish_phase();
         sent += count;
      end
   endtask

   initial begin
      reset               <= 1'b1;
      csr_we              <= 1'b0;
      csr_wdata           <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.random_word <= '0;
      restart_permutation();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_default();
      test_size_zero();
      test_size_one();
      test_size_two();
      test_wrap_and_rewrite();
      test_size_saturate();
      test_full_permutation();
      test_back_pressure();
      test_no_idling();
      test_random_sizes();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_values.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #80_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ----- sim.f -----
design/spg_pkg.sv
design/spg_req_if.sv
design/spg_rsp_if.sv
design/shuffle_permutation_generator.sv
verif/testbench.sv
